@@ design/y4m_pkg.sv @@
// Shared types, constants and character tables for the Y4M luma extractor.
package y4m_pkg;

	localparam int MAX_DIM = 4096;
	localparam int DIM_W   = $clog2(MAX_DIM + 2);
	localparam int PLANE_W = $clog2(2 * MAX_DIM * MAX_DIM);

	typedef logic [DIM_W-1:0]   dim_t;
	typedef logic [PLANE_W-1:0] plane_t;
	typedef logic [3:0]         tok_idx_t;

	typedef enum logic [3:0] {
		PH_MAGIC_SKIP = 4'd0,
		PH_MAGIC_TOK  = 4'd1,
		PH_SEP        = 4'd2,
		PH_TAG        = 4'd3,
		PH_NUM_SKIP   = 4'd4,
		PH_NUM_DIG    = 4'd5,
		PH_TOK_SKIP   = 4'd6,
		PH_TOK_BODY   = 4'd7,
		PH_CHAR_SKIP  = 4'd8,
		PH_FRM_SKIP   = 4'd9,
		PH_FRM_TOK    = 4'd10,
		PH_DATA       = 4'd11,
		PH_HALT       = 4'd12
	} phase_t;

	typedef enum logic [1:0] {
		ST_LUMA  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0] luma;
		logic       frame_last;
		status_t    status;
	} out_item_t;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_W       = 8'h57;
	localparam logic [7:0] CH_H       = 8'h48;
	localparam logic [7:0] CH_I       = 8'h49;

	localparam tok_idx_t MAGIC_LEN = 4'd9;
	localparam tok_idx_t FRAME_LEN = 4'd5;
	localparam tok_idx_t TOK_SAT   = 4'd15;

	// Characters of the stream magic token YUV4MPEG2.
	function automatic logic [7:0] magic_char(input tok_idx_t idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h59;
			4'd1:    c = 8'h55;
			4'd2:    c = 8'h56;
			4'd3:    c = 8'h34;
			4'd4:    c = 8'h4D;
			4'd5:    c = 8'h50;
			4'd6:    c = 8'h45;
			4'd7:    c = 8'h47;
			4'd8:    c = 8'h32;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Characters of the frame token FRAME.
	function automatic logic [7:0] frame_char(input tok_idx_t idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h46;
			4'd1:    c = 8'h52;
			4'd2:    c = 8'h41;
			4'd3:    c = 8'h4D;
			4'd4:    c = 8'h45;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

@@ design/y4m_parser.sv @@
// Byte-serial Y4M parser: header and frame-token state machine, dimension and plane counters.
module y4m_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  y4m_pkg::in_item_t  item,
	output logic               res_valid,
	output y4m_pkg::out_item_t res
);

	y4m_pkg::phase_t   phase_q, phase_d;
	y4m_pkg::tok_idx_t tok_q, tok_d, tok_inc;
	logic              mism_q, mism_d;
	y4m_pkg::dim_t     width_q, width_d, height_q, height_d;
	y4m_pkg::plane_t   plane_q, plane_d, luma_size_q, chroma_size_q, total_q;

	logic [7:0] b;
	logic       eos;
	logic       is_sp, is_nl, is_ws, is_dig;
	logic       dims_ok, magic_hit, frame_hit, magic_ok, frame_ok;
	logic       sep_err_hdr, sep_err_frm, sep_err_cur;
	logic [3:0] digit;
	logic [y4m_pkg::DIM_W+3:0] acc_src, acc;
	y4m_pkg::dim_t     acc_sat;
	y4m_pkg::plane_t   plane_inc;

	assign b      = item.stream_byte;
	assign eos    = item.end_of_stream;
	assign is_sp  = (b == y4m_pkg::CH_SPACE);
	assign is_nl  = (b == y4m_pkg::CH_NEWLINE);
	assign is_ws  = is_sp || (b >= y4m_pkg::CH_TAB && b <= y4m_pkg::CH_CR);
	assign is_dig = (b >= y4m_pkg::CH_ZERO) && (b <= y4m_pkg::CH_NINE);
	assign digit  = 4'(b - y4m_pkg::CH_ZERO);

	assign dims_ok = (width_q != '0) && (width_q <= y4m_pkg::dim_t'(y4m_pkg::MAX_DIM)) &&
		(height_q != '0) && (height_q <= y4m_pkg::dim_t'(y4m_pkg::MAX_DIM));

	assign magic_hit = (tok_q < y4m_pkg::MAGIC_LEN) && (b == y4m_pkg::magic_char(tok_q));
	assign frame_hit = (tok_q < y4m_pkg::FRAME_LEN) && (b == y4m_pkg::frame_char(tok_q));
	assign magic_ok  = !mism_q && (tok_q == y4m_pkg::MAGIC_LEN);
	assign frame_ok  = !mism_q && (tok_q == y4m_pkg::FRAME_LEN);
	assign tok_inc   = (tok_q == y4m_pkg::TOK_SAT) ? tok_q : tok_q + 4'd1;

	// A separator is a space (next tag) or a newline (end of header); the main header
	// also needs valid dimensions at its newline.
	assign sep_err_hdr = !is_sp && (!is_nl || !dims_ok);
	assign sep_err_frm = !is_sp && !is_nl;
	assign sep_err_cur = (tok_q == '0) ? sep_err_hdr : sep_err_frm;

	// Decimal accumulation, times ten as two shifts, saturating just past the limit.
	assign acc_src = ((tok_q == '0) ? {4'd0, width_q} : {4'd0, height_q});
	assign acc     = (acc_src << 3) + (acc_src << 1) + {{y4m_pkg::DIM_W{1'b0}}, digit};
	assign acc_sat = (acc > (y4m_pkg::DIM_W + 4)'(y4m_pkg::MAX_DIM)) ?
		y4m_pkg::dim_t'(y4m_pkg::MAX_DIM + 1) : acc[y4m_pkg::DIM_W-1:0];

	assign plane_inc = plane_q + y4m_pkg::plane_t'(1);

	function automatic y4m_pkg::phase_t sep_phase(input logic hdr_ctx, input logic sp,
			input logic nl, input logic ok);
		y4m_pkg::phase_t p;
		if (sp) begin
			p = y4m_pkg::PH_TAG;
		end else if (!nl) begin
			p = y4m_pkg::PH_HALT;
		end else if (hdr_ctx) begin
			p = ok ? y4m_pkg::PH_FRM_SKIP : y4m_pkg::PH_HALT;
		end else begin
			p = y4m_pkg::PH_DATA;
		end
		return p;
	endfunction

	// Next state.
	always_comb begin
		phase_d  = phase_q;
		tok_d    = tok_q;
		mism_d   = mism_q;
		width_d  = width_q;
		height_d = height_q;
		plane_d  = plane_q;
		if (step && phase_q != y4m_pkg::PH_HALT) begin
			if (eos) begin
				phase_d = y4m_pkg::PH_HALT;
			end else begin
				case (phase_q)
					y4m_pkg::PH_MAGIC_SKIP: begin
						if (!is_ws) begin
							tok_d   = 4'd1;
							mism_d  = (b != y4m_pkg::magic_char('0));
							phase_d = y4m_pkg::PH_MAGIC_TOK;
						end
					end
					y4m_pkg::PH_MAGIC_TOK: begin
						if (!is_ws) begin
							mism_d = mism_q || !magic_hit;
							tok_d  = tok_inc;
						end else if (!magic_ok) begin
							phase_d = y4m_pkg::PH_HALT;
						end else begin
							tok_d   = '0;
							phase_d = sep_phase(1'b1, is_sp, is_nl, dims_ok);
						end
					end
					y4m_pkg::PH_SEP: begin
						phase_d = sep_phase(tok_q == '0, is_sp, is_nl, dims_ok);
					end
					y4m_pkg::PH_TAG: begin
						if (tok_q != '0) begin
							phase_d = y4m_pkg::PH_TOK_SKIP;
						end else if (b == y4m_pkg::CH_W) begin
							phase_d = y4m_pkg::PH_NUM_SKIP;
						end else if (b == y4m_pkg::CH_H) begin
							tok_d   = 4'd1;
							phase_d = y4m_pkg::PH_NUM_SKIP;
						end else if (b == y4m_pkg::CH_I) begin
							phase_d = y4m_pkg::PH_CHAR_SKIP;
						end else begin
							phase_d = y4m_pkg::PH_TOK_SKIP;
						end
					end
					y4m_pkg::PH_NUM_SKIP: begin
						if (!is_ws) begin
							if (!is_dig) begin
								phase_d = y4m_pkg::PH_HALT;
							end else begin
								if (tok_q == '0) begin
									width_d = y4m_pkg::dim_t'(digit);
								end else begin
									height_d = y4m_pkg::dim_t'(digit);
								end
								phase_d = y4m_pkg::PH_NUM_DIG;
							end
						end
					end
					y4m_pkg::PH_NUM_DIG: begin
						if (is_dig) begin
							if (tok_q == '0) begin
								width_d = acc_sat;
							end else begin
								height_d = acc_sat;
							end
						end else begin
							tok_d   = '0;
							phase_d = sep_phase(1'b1, is_sp, is_nl, dims_ok);
						end
					end
					y4m_pkg::PH_TOK_SKIP: begin
						if (!is_ws) begin
							phase_d = y4m_pkg::PH_TOK_BODY;
						end
					end
					y4m_pkg::PH_TOK_BODY: begin
						if (is_ws) begin
							phase_d = sep_phase(tok_q == '0, is_sp, is_nl, dims_ok);
						end
					end
					y4m_pkg::PH_CHAR_SKIP: begin
						if (!is_ws) begin
							phase_d = y4m_pkg::PH_SEP;
						end
					end
					y4m_pkg::PH_FRM_SKIP: begin
						if (!is_ws) begin
							tok_d   = 4'd1;
							mism_d  = (b != y4m_pkg::frame_char('0));
							phase_d = y4m_pkg::PH_FRM_TOK;
						end
					end
					y4m_pkg::PH_FRM_TOK: begin
						if (!is_ws) begin
							mism_d = mism_q || !frame_hit;
							tok_d  = tok_inc;
						end else if (!frame_ok) begin
							phase_d = y4m_pkg::PH_HALT;
						end else begin
							tok_d   = 4'd1;
							phase_d = sep_phase(1'b0, is_sp, is_nl, dims_ok);
						end
					end
					y4m_pkg::PH_DATA: begin
						plane_d = plane_inc;
						if (plane_inc == total_q) begin
							phase_d = y4m_pkg::PH_FRM_SKIP;
						end
					end
					default: begin
						phase_d = y4m_pkg::PH_HALT;
					end
				endcase
			end
			if (phase_d == y4m_pkg::PH_DATA && phase_q != y4m_pkg::PH_DATA) begin
				plane_d = '0;
			end
		end
	end

	// Result of the item being taken.
	always_comb begin
		res_valid      = 1'b0;
		res.luma       = '0;
		res.frame_last = 1'b0;
		res.status     = y4m_pkg::ST_ERROR;
		if (step && phase_q != y4m_pkg::PH_HALT) begin
			if (eos) begin
				res_valid = 1'b1;
				if (phase_q == y4m_pkg::PH_FRM_SKIP) begin
					res.status = y4m_pkg::ST_DONE;
				end else if (phase_q == y4m_pkg::PH_FRM_TOK && !frame_ok) begin
					res.status = y4m_pkg::ST_DONE;
				end
			end else begin
				case (phase_q)
					y4m_pkg::PH_MAGIC_TOK: begin
						res_valid = is_ws && (!magic_ok || sep_err_hdr);
					end
					y4m_pkg::PH_SEP: begin
						res_valid = sep_err_cur;
					end
					y4m_pkg::PH_NUM_SKIP: begin
						res_valid = !is_ws && !is_dig;
					end
					y4m_pkg::PH_NUM_DIG: begin
						res_valid = !is_dig && sep_err_hdr;
					end
					y4m_pkg::PH_TOK_BODY: begin
						res_valid = is_ws && sep_err_cur;
					end
					y4m_pkg::PH_FRM_TOK: begin
						res_valid = is_ws && (!frame_ok || sep_err_frm);
						if (!frame_ok) begin
							res.status = y4m_pkg::ST_DONE;
						end
					end
					y4m_pkg::PH_DATA: begin
						if (plane_q < luma_size_q) begin
							res_valid      = 1'b1;
							res.luma       = b;
							res.frame_last = (plane_inc == luma_size_q);
							res.status     = y4m_pkg::ST_LUMA;
						end
					end
					default: begin
						res_valid = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= y4m_pkg::PH_MAGIC_SKIP;
			tok_q    <= '0;
			mism_q   <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			plane_q  <= '0;
		end else begin
			phase_q  <= phase_d;
			tok_q    <= tok_d;
			mism_q   <= mism_d;
			width_q  <= width_d;
			height_q <= height_d;
			plane_q  <= plane_d;
		end
	end

	// Plane sizes follow the dimension registers; they settle long before the
	// first data byte, since a frame token has to be parsed first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_size_q   <= '0;
			chroma_size_q <= '0;
			total_q       <= '0;
		end else begin
			luma_size_q   <= y4m_pkg::plane_t'(width_q) * y4m_pkg::plane_t'(height_q);
			chroma_size_q <= (y4m_pkg::plane_t'(height_q >> 1) *
				y4m_pkg::plane_t'(width_q >> 1)) << 1;
			total_q       <= luma_size_q + chroma_size_q;
		end
	end

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == y4m_pkg::PH_HALT |=> phase_q == y4m_pkg::PH_HALT)
		else $error("parser left the halted state");

	a_final_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status != y4m_pkg::ST_LUMA) |=> phase_q == y4m_pkg::PH_HALT)
		else $error("finish or error result without halting");

	a_luma_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == y4m_pkg::ST_LUMA) |->
		(phase_q == y4m_pkg::PH_DATA && plane_q < luma_size_q))
		else $error("luma sample outside the luma plane");

	a_plane_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == y4m_pkg::PH_DATA |-> plane_q < total_q)
		else $error("plane counter ran past the frame size");

endmodule

@@ design/y4m_luma_extractor.sv @@
// Top level of the Y4M luma extractor: input handshake and registered result stage.
//
// The block takes a YUV4MPEG2 file one byte per item on the input channel
// (in_valid, in_ready, in_data) and returns the luma samples of every frame on
// the output channel (out_valid, out_ready, out_data). Header and frame-token
// bytes and the 4:2:0 chroma planes produce no item. The last luma sample of
// each frame carries frame_last. When the stream ends cleanly (end_of_stream
// where a frame token is expected, or a token other than FRAME) one item with
// status 1 is sent; a malformed or truncated stream sends one item with
// status 2. After either, the block keeps taking bytes but returns nothing
// until the next reset.
// Throughput is one byte per cycle. A result is loaded into the output register
// in the cycle after its byte is taken, and the next byte is taken in that same
// cycle whenever the output register is empty or is being drained. If the
// receiver holds out_ready low with a result pending, in_ready drops until
// that result is taken. The asynchronous reset arst_n returns the parser to
// the search for the YUV4MPEG2 token and empties the output register.
module y4m_luma_extractor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  y4m_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output y4m_pkg::out_item_t out_data
);

	logic               step;
	logic               res_valid;
	y4m_pkg::out_item_t res;
	logic               out_valid_q;
	y4m_pkg::out_item_t out_data_q;

	// The output register can take a new result when it is empty or its
	// current item leaves in this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	y4m_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (in_data),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload carries no reset; it is qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
